FILE: hw/rtl/kdpc_pkg.sv
// Shared types and constants of the key debounce and press classifier.
`timescale 1ns / 1ps

package kdpc_pkg;

    localparam int DB_W    = 8;
    localparam int HOLD_W  = 16;
    localparam int EV_W    = 2;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [PHASE_W-1:0] PH_IDLE       = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PRESS_DB   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PRESSED    = 2'd2;
    localparam logic [PHASE_W-1:0] PH_RELEASE_DB = 2'd3;

    localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_W-1:0] EV_SHORT = 2'd1;
    localparam logic [EV_W-1:0] EV_LONG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 1'b1;

    localparam logic [DB_W-1:0]   DEBOUNCE_COUNT_RST   = 8'd3;
    localparam logic [HOLD_W-1:0] LONG_PRESS_TICKS_RST = 16'd500;

    localparam logic [DB_W-1:0]   DB_MAX   = {DB_W{1'b1}};
    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

    typedef logic [EV_W-1:0] t_event;

    typedef struct packed {
        logic [DB_W-1:0]   debounce_count;
        logic [HOLD_W-1:0] long_press_ticks;
    } t_cfg;

endpackage

FILE: hw/rtl/kdpc_lane.sv
// Per-key debounce state machine with hold counter and press classification.
`timescale 1ns / 1ps

module kdpc_lane (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_level,
    input  kdpc_pkg::t_cfg   i_cfg,
    output kdpc_pkg::t_event o_event
);
    import kdpc_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [DB_W-1:0]    r_bounce, n_bounce;
    logic [HOLD_W-1:0]  r_hold, n_hold;
    logic               r_long_reported, n_long_reported;
    t_event             ev;

    logic [DB_W-1:0]   bounce_inc;
    logic [HOLD_W-1:0] hold_inc;
    logic              bounce_ok;

    assign bounce_inc = (r_bounce == DB_MAX) ? DB_MAX : r_bounce + 1'b1;
    assign hold_inc   = (r_hold == HOLD_MAX) ? HOLD_MAX : r_hold + 1'b1;
    assign bounce_ok  = bounce_inc >= i_cfg.debounce_count;

    always_comb begin
        n_phase         = r_phase;
        n_bounce        = r_bounce;
        n_hold          = r_hold;
        n_long_reported = r_long_reported;
        ev              = EV_NONE;
        case (r_phase)
            PH_IDLE: begin
                if (!i_level) begin
                    n_phase         = PH_PRESS_DB;
                    n_long_reported = 1'b0;
                    n_hold          = '0;
                end
            end
            PH_PRESS_DB: begin
                if (!i_level) begin
                    n_bounce = bounce_inc;
                    if (bounce_ok) begin
                        n_phase  = PH_PRESSED;
                        n_bounce = '0;
                    end
                end else begin
                    n_bounce = '0;
                    n_phase  = PH_IDLE;
                end
            end
            PH_PRESSED: begin
                n_hold = hold_inc;
                if (i_level) begin
                    n_phase = PH_RELEASE_DB;
                end
                if (hold_inc >= i_cfg.long_press_ticks) begin
                    if (!r_long_reported) begin
                        ev              = EV_LONG;
                        n_long_reported = 1'b1;
                    end
                    n_hold = i_cfg.long_press_ticks;
                end
            end
            default: begin
                if (i_level) begin
                    n_bounce = bounce_inc;
                    if (bounce_ok) begin
                        n_phase  = PH_IDLE;
                        n_bounce = '0;
                        if (!r_long_reported) begin
                            ev = EV_SHORT;
                        end
                    end
                end else begin
                    n_bounce = '0;
                    n_phase  = PH_PRESSED;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_bounce        <= '0;
            r_hold          <= '0;
            r_long_reported <= 1'b0;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_bounce        <= n_bounce;
            r_hold          <= n_hold;
            r_long_reported <= n_long_reported;
        end
    end

    assign o_event = ev;

    a_long_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && ev == EV_LONG) |=> r_long_reported)
        else $error("long event did not mark the press as reported");

    a_short_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && ev == EV_SHORT) |=> (r_phase == PH_IDLE && r_bounce == '0))
        else $error("short event did not return the key to idle");

    a_hold_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> ($stable(r_phase) && $stable(r_hold) && $stable(r_bounce)))
        else $error("key state moved without an accepted request");

endmodule

FILE: hw/rtl/kdpc_merge.sv
// Merging stage that packs the lane events into the registered result.
`timescale 1ns / 1ps

module kdpc_merge #(
    parameter int NUM_KEYS = 3,
    parameter int OUT_W    = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  kdpc_pkg::t_event [NUM_KEYS-1:0]      i_events,
    input  logic                                 i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [OUT_W-1:0]                     o_m_tdata,
    output logic                                 o_s_tready
);
    import kdpc_pkg::*;

    logic             r_valid;
    logic [OUT_W-1:0] r_data, n_data;

    always_comb begin
        n_data = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            n_data[k*EV_W +: EV_W] = i_events[k];
        end
    end

    assign o_s_tready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_data <= n_data;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule

FILE: hw/rtl/key_debounce_press_classifier.sv
// Top level of the key debounce and short/long press classifier.
//
// Channel   Direction  Handshake             Payload
// s_axis    in         i_s_tvalid/o_s_tready  one scan tick, one level bit per key
// m_axis    out        o_m_tvalid/i_m_tready  one event per key for every tick
// cfg       in         i_cfg_we               debounce count, long press ticks
//
// One scan tick is accepted every cycle while the output is not stalled; the per-key
// state update of each lane completes in that cycle and its result lands in the
// output register in the cycle after acceptance. A stalled output keeps its result
// while one more tick may be accepted in the cycle it is taken. Reset clears every
// key to idle and loads the default register values; no clearing pass is needed.
`timescale 1ns / 1ps

module key_debounce_press_classifier #(
    parameter int NUM_KEYS = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // Fields from bit 0 up: key0_level, key1_level, ... one bit per key.
    input  logic [((NUM_KEYS+7)/8)*8-1:0]          i_s_tdata,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // Fields from bit 0 up: key0_event, key1_event, ... two bits per key.
    output logic [((NUM_KEYS*kdpc_pkg::EV_W+7)/8)*8-1:0] o_m_tdata,
    input  logic                                   i_cfg_we,
    input  logic [kdpc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [kdpc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import kdpc_pkg::*;

    localparam int OUT_W = ((NUM_KEYS*EV_W+7)/8)*8;

    t_cfg                   r_cfg;
    t_event [NUM_KEYS-1:0]  lane_events;
    logic                   s_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_count   <= DEBOUNCE_COUNT_RST;
            r_cfg.long_press_ticks <= LONG_PRESS_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEBOUNCE_COUNT:   r_cfg.debounce_count   <= i_cfg_data[DB_W-1:0];
                REG_LONG_PRESS_TICKS: r_cfg.long_press_ticks <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_accept = i_s_tvalid && o_s_tready;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        kdpc_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_accept (s_accept),
            .i_level  (i_s_tdata[k]),
            .i_cfg    (r_cfg),
            .o_event  (lane_events[k])
        );
    end

    kdpc_merge #(
        .NUM_KEYS (NUM_KEYS),
        .OUT_W    (OUT_W)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (s_accept),
        .i_events   (lane_events),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_s_tready (o_s_tready)
    );

endmodule
